/* sv/ple_pkg.sv */
// Shared types and constants for the positional list engine.
// No dependencies; imported by ple_cell, the top level and the testbench.
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_LIST      = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    // What a cell does at the next edge
    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_LOAD       = 2'd1,
        OP_FROM_LEFT  = 2'd2,
        OP_FROM_RIGHT = 2'd3
    } cell_op_t;

endpackage

/* sv/positional_list_engine_unit.sv */
// Top level of the positional list engine: controller, output register
// and a chain of ple_cell instances. Depends on ple_pkg and ple_cell.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_command, s_value, s_position
//  m_       out        m_valid / m_ready  m_status, m_element, m_count, m_last
//
// Inserts and deletes shift the cell chain as they are accepted: one item per
// cycle while results are taken. During a list command the chain rotates left
// by one cell per result, so after the walk it is back in order.
// aresetn (synchronous) empties the list; cell contents are not cleared.
// A stalled m_ side holds the result register and freezes the walk.
module positional_list_engine_unit
    import ple_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_command,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic [4:0]               s_position,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [DATA_W-1:0] m_element,
    output logic [4:0]               m_count,
    output logic                     m_last
);

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic [CNT_W-1:0]         walk_reg, walk_next;
    logic                     m_valid_reg, m_valid_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] element_reg, element_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     last_reg, last_next;

    cell_op_t                 cell_op [CAPACITY];
    logic signed [DATA_W-1:0] cell_q  [CAPACITY];
    logic signed [DATA_W-1:0] din_bus;

    logic                     out_free;
    logic                     accept;
    logic                     pos_ok;
    logic [CNT_W-1:0]         pos_idx;
    logic [CNT_W-1:0]         ins_idx;
    logic [CNT_W-1:0]         del_idx;
    logic                     do_ins;
    logic                     do_del;
    logic                     do_rot;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_chain
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;
            if (g == 0) begin : g_head
                assign left_d = cell_q[g];
            end else begin : g_mid_l
                assign left_d = cell_q[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign right_d = cell_q[g];
            end else begin : g_mid_r
                assign right_d = cell_q[g+1];
            end
            ple_cell u_cell (
                .aclk  (aclk),
                .op    (cell_op[g]),
                .din   (din_bus),
                .left  (left_d),
                .right (right_d),
                .q     (cell_q[g])
            );
        end
    endgenerate

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign pos_ok  = (s_position != '0) && (CNT_W'(s_position) <= occ_reg);
    assign pos_idx = CNT_W'(s_position) - CNT_W'(1);

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        walk_next    = walk_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        element_next = element_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        ins_idx      = '0;
        del_idx      = '0;
        do_ins       = 1'b0;
        do_del       = 1'b0;
        do_rot       = 1'b0;
        din_bus      = s_value;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    status_next  = STAT_OK;
                    element_next = '0;
                    last_next    = 1'b1;
                    unique case (s_command)
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
                            if (occ_reg == CNT_W'(CAPACITY)) begin
                                status_next = STAT_FULL;
                            end else if (s_command == CMD_INS_FRONT) begin
                                do_ins  = 1'b1;
                                ins_idx = '0;
                            end else if (s_command == CMD_INS_BACK || occ_reg == '0) begin
                                do_ins  = 1'b1;
                                ins_idx = occ_reg;
                            end else if (pos_ok) begin
                                do_ins  = 1'b1;
                                ins_idx = pos_idx;
                            end else begin
                                status_next = STAT_BADPOS;
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                            if (occ_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else if (s_command == CMD_DEL_FRONT) begin
                                do_del  = 1'b1;
                                del_idx = '0;
                            end else if (s_command == CMD_DEL_BACK) begin
                                do_del  = 1'b1;
                                del_idx = occ_reg - CNT_W'(1);
                            end else if (pos_ok) begin
                                do_del  = 1'b1;
                                del_idx = pos_idx;
                            end else begin
                                status_next = STAT_BADPOS;
                            end
                        end
                        CMD_LIST: begin
                            if (occ_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                // results come from the walk, not from here
                                m_valid_next = 1'b0;
                                walk_next    = '0;
                                state_next   = ST_LIST;
                            end
                        end
                        default: ;
                    endcase
                    if (do_ins) begin
                        occ_next = occ_reg + CNT_W'(1);
                    end
                    if (do_del) begin
                        occ_next     = occ_reg - CNT_W'(1);
                        element_next = cell_q[del_idx[IDX_W-1:0]];
                    end
                    count_next = occ_next;
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    // emit the head, then rotate it to the tail of the list
                    do_rot       = 1'b1;
                    din_bus      = cell_q[0];
                    m_valid_next = 1'b1;
                    status_next  = STAT_OK;
                    element_next = cell_q[0];
                    count_next   = occ_reg;
                    last_next    = (walk_reg == occ_reg - CNT_W'(1));
                    walk_next    = walk_reg + CNT_W'(1);
                    if (walk_reg == occ_reg - CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_op[i] = OP_HOLD;
            if (do_ins) begin
                if (CNT_W'(i) > ins_idx) begin
                    cell_op[i] = OP_FROM_LEFT;
                end else if (CNT_W'(i) == ins_idx) begin
                    cell_op[i] = OP_LOAD;
                end
            end else if (do_del) begin
                if (CNT_W'(i) >= del_idx) begin
                    cell_op[i] = OP_FROM_RIGHT;
                end
            end else if (do_rot) begin
                if (CNT_W'(i) == occ_reg - CNT_W'(1)) begin
                    cell_op[i] = OP_LOAD;
                end else if (CNT_W'(i) < occ_reg) begin
                    cell_op[i] = OP_FROM_RIGHT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            walk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            walk_reg    <= walk_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg  <= status_next;
        element_reg <= element_next;
        count_reg   <= count_next;
        last_reg    <= last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = status_reg;
    assign m_element = element_reg;
    assign m_count   = count_reg;
    assign m_last    = last_reg;

endmodule

/* sv/ple_cell.sv */
// One storage cell of the list chain: holds one element, loads new data
// or takes its neighbor's. Depends on ple_pkg.
module ple_cell
    import ple_pkg::*;
(
    input  logic                     aclk,
    input  cell_op_t                 op,
    input  logic signed [DATA_W-1:0] din,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0] q
);

    logic signed [DATA_W-1:0] slot_reg;
    logic signed [DATA_W-1:0] slot_next;

    always_comb begin
        unique case (op)
            OP_HOLD:       slot_next = slot_reg;
            OP_LOAD:       slot_next = din;
            OP_FROM_LEFT:  slot_next = left;
            OP_FROM_RIGHT: slot_next = right;
            default:       slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign q = slot_reg;

endmodule

/* dv/positional_list_engine_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench for positional_list_engine_unit: a directed table of list edits,
// then random edits and walks, checked against the table and an in-bench list model.
// Depends on ple_pkg and the positional_list_engine_unit RTL.
module positional_list_engine_unit_tb;
    import ple_pkg::*;

    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam int         RANDOM_ITEMS = 450;
    localparam int         CALM_ITEMS   = 60;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         TAIL_CYCLES  = 20;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic [4:0]               count;
        logic                     is_last;
    } list_result_t;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] value;
        logic [4:0]               position;
        logic [4:0]               reps;
        logic                     typed;
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic [4:0]               count;
    } stim_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [2:0]               s_command;
    logic signed [DATA_W-1:0] s_value;
    logic [4:0]               s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic [1:0]               m_status;
    logic signed [DATA_W-1:0] m_element;
    logic [4:0]               m_count;
    logic                     m_last;

    logic signed [DATA_W-1:0] shadow_list[$];
    list_result_t             fresh_results[$];
    list_result_t             awaited_results[$];
    stim_row_t                directed_rows[$];
    int                       mismatch_count = 0;
    int                       gap_odds = 2;
    bit                       quiet = 1'b0;

    cmd_t insert_cmds[3] = '{CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS};
    cmd_t delete_cmds[3] = '{CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS};

    positional_list_engine_unit uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_value    (s_value),
        .s_position (s_position),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_element  (m_element),
        .m_count    (m_count),
        .m_last     (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void note_result(input status_t status,
                                        input logic signed [DATA_W-1:0] element,
                                        input logic is_last);
        list_result_t res;
        res.status  = status;
        res.element = element;
        res.count   = 5'(shadow_list.size());
        res.is_last = is_last;
        fresh_results.push_back(res);
    endfunction

    // Apply one command to the shadow list and collect the results it causes
    function automatic void predict_command(input logic [2:0] cmd,
                                            input logic signed [DATA_W-1:0] value,
                                            input logic [4:0] position);
        int n;
        logic signed [DATA_W-1:0] taken;
        n = shadow_list.size();
        fresh_results.delete();
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
                if (n >= CAPACITY) begin
                    note_result(STAT_FULL, '0, 1'b1);
                end else if (cmd == CMD_INS_FRONT) begin
                    shadow_list.push_front(value);
                    note_result(STAT_OK, '0, 1'b1);
                end else if (cmd == CMD_INS_BACK || n == 0) begin
                    // an empty list takes the element whatever the position
                    shadow_list.push_back(value);
                    note_result(STAT_OK, '0, 1'b1);
                end else if (position < 1 || position > n) begin
                    note_result(STAT_BADPOS, '0, 1'b1);
                end else begin
                    shadow_list.insert(position - 1, value);
                    note_result(STAT_OK, '0, 1'b1);
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                if (n == 0) begin
                    note_result(STAT_EMPTY, '0, 1'b1);
                end else if (cmd == CMD_DEL_FRONT) begin
                    taken = shadow_list.pop_front();
                    note_result(STAT_OK, taken, 1'b1);
                end else if (cmd == CMD_DEL_BACK) begin
                    taken = shadow_list.pop_back();
                    note_result(STAT_OK, taken, 1'b1);
                end else if (position < 1 || position > n) begin
                    note_result(STAT_BADPOS, '0, 1'b1);
                end else begin
                    taken = shadow_list[position - 1];
                    shadow_list.delete(position - 1);
                    note_result(STAT_OK, taken, 1'b1);
                end
            end
            CMD_LIST: begin
                if (n == 0) begin
                    note_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    for (int k = 0; k < n; k++)
                        note_result(STAT_OK, shadow_list[k], k == n - 1);
                end
            end
            default: begin
                note_result(STAT_OK, '0, 1'b1);
            end
        endcase
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic signed [DATA_W-1:0] value,
                           input logic [4:0] position, input logic [4:0] reps,
                           input logic typed, input status_t status,
                           input logic signed [DATA_W-1:0] element, input logic [4:0] count);
        stim_row_t row;
        row.cmd      = cmd;
        row.value    = value;
        row.position = position;
        row.reps     = reps;
        row.typed    = typed;
        row.status   = status;
        row.element  = element;
        row.count    = count;
        directed_rows.push_back(row);
    endtask

    // Present one item from a falling edge, hold it until accepted
    task automatic send_item(input logic [2:0] cmd, input logic signed [DATA_W-1:0] value,
                             input logic [4:0] position, input bit has_typed,
                             input list_result_t typed_res);
        int gap;
        if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_value    <= value;
        s_position <= position;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_command(cmd, value, position);
        if (has_typed)
            awaited_results.push_back(typed_res);
        else
            foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
        @(negedge aclk);
    endtask

    initial begin : drive_commands
        stim_row_t    row;
        list_result_t typed_res;
        int           i;
        int           r;
        int           n;
        int           roll;
        bit           growing;
        logic [2:0]   cmd;
        logic [4:0]   pos;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_command  = CMD_INS_FRONT;
        s_value    = '0;
        s_position = '0;
        growing    = 1'b1;

        add_row(CMD_LIST,      0,          0,  1, 1, STAT_EMPTY,  0,       0);
        add_row(CMD_DEL_FRONT, 0,          0,  1, 1, STAT_EMPTY,  0,       0);
        add_row(CMD_DEL_BACK,  0,          0,  1, 1, STAT_EMPTY,  0,       0);
        add_row(CMD_DEL_POS,   0,          1,  1, 1, STAT_EMPTY,  0,       0);
        add_row(CMD_UNUSED,    VAL_MAX,    31, 1, 1, STAT_OK,     0,       0);
        add_row(CMD_INS_POS,   VAL_MIN,    0,  1, 1, STAT_OK,     0,       1);
        add_row(CMD_DEL_POS,   0,          1,  1, 1, STAT_OK,     VAL_MIN, 0);
        add_row(CMD_INS_POS,   VAL_MAX,    31, 1, 1, STAT_OK,     0,       1);
        add_row(CMD_INS_FRONT, -1,         0,  1, 1, STAT_OK,     0,       2);
        add_row(CMD_INS_BACK,  0,          0,  1, 1, STAT_OK,     0,       3);
        add_row(CMD_INS_POS,   5,          1,  1, 1, STAT_OK,     0,       4);
        add_row(CMD_INS_POS,   7,          0,  1, 1, STAT_BADPOS, 0,       4);
        add_row(CMD_INS_POS,   7,          5,  1, 1, STAT_BADPOS, 0,       4);
        add_row(CMD_INS_POS,   'h55555555, 4,  1, 1, STAT_OK,     0,       5);
        add_row(CMD_LIST,      0,          0,  1, 0, STAT_OK,     0,       0);
        add_row(CMD_DEL_POS,   0,          0,  1, 1, STAT_BADPOS, 0,       5);
        add_row(CMD_DEL_POS,   0,          31, 1, 1, STAT_BADPOS, 0,       5);
        add_row(CMD_DEL_POS,   0,          6,  1, 1, STAT_BADPOS, 0,       5);
        add_row(CMD_DEL_POS,   0,          3,  1, 0, STAT_OK,     0,       0);
        add_row(CMD_DEL_FRONT, 0,          0,  1, 0, STAT_OK,     0,       0);
        add_row(CMD_DEL_BACK,  0,          0,  1, 0, STAT_OK,     0,       0);
        // fill to capacity
        add_row(CMD_INS_BACK,  'hAAAAAAAA, 0,  14, 0, STAT_OK,    0,       0);
        add_row(CMD_INS_FRONT, 1,          0,  1, 1, STAT_FULL,   0,       16);
        add_row(CMD_INS_POS,   1,          1,  1, 1, STAT_FULL,   0,       16);
        add_row(CMD_LIST,      0,          0,  1, 0, STAT_OK,     0,       0);
        add_row(CMD_DEL_POS,   0,          16, 1, 0, STAT_OK,     0,       0);
        add_row(CMD_UNUSED,    0,          0,  1, 1, STAT_OK,     0,       15);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < directed_rows.size(); i++) begin
            row = directed_rows[i];
            typed_res = '{row.status, row.element, row.count, 1'b1};
            for (r = 0; r < row.reps; r++)
                send_item(row.cmd, row.value, row.position, row.typed, typed_res);
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            n = shadow_list.size();
            if (i % 32 == 0) gap_odds = $urandom_range(0, 3);
            if (i == RANDOM_ITEMS - CALM_ITEMS) quiet = 1'b1;
            // swing the list between empty and full
            if (n == CAPACITY)
                growing = 1'b0;
            else if (n == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                growing = !growing;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                cmd = CMD_UNUSED;
            else if (roll < 12)
                cmd = CMD_LIST;
            else if ($urandom_range(0, 99) < (growing ? 70 : 30))
                cmd = insert_cmds[$urandom_range(0, 2)];
            else
                cmd = delete_cmds[$urandom_range(0, 2)];
            if ($urandom_range(0, 4) == 0)
                pos = 5'($urandom_range(0, 31));
            else
                pos = 5'($urandom_range(1, n == 0 ? 1 : n));
            send_item(cmd, $urandom(), pos, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : take_results
        int hold_odds;
        m_ready   = 1'b0;
        hold_odds = 2;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 63) == 0) hold_odds = $urandom_range(0, 3);
            if (!quiet && hold_odds != 0 && $urandom_range(0, hold_odds * 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result: status %0d element %0d count %0d",
                                          m_status, m_element, m_count));
            end else begin
                want = awaited_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              m_status, want.status));
                if (m_element !== want.element)
                    report_mismatch($sformatf("element got %0d expected %0d",
                                              m_element, want.element));
                if (m_count !== want.count)
                    report_mismatch($sformatf("count got %0d expected %0d",
                                              m_count, want.count));
                if (m_last !== want.is_last)
                    report_mismatch($sformatf("last got %0b expected %0b",
                                              m_last, want.is_last));
            end
        end
    end

    // End the run when neither side moves an item for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
